@@ rtl/blv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blv_pkg
// Shared types for the bounded list unit: request codes, status codes,
// entry type and the per-cell data select.
// ----------------------------------------------------------------------------
package blv_pkg;

  // stored entry
  typedef logic signed [31:0] value_t;

  // request kinds
  typedef enum logic [2:0] {
    REQ_INS_BACK  = 3'd0,
    REQ_INS_FRONT = 3'd1,
    REQ_DEL_VALUE = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_BACK  = 3'd4,
    REQ_DISPLAY   = 3'd5
  } req_t;

  // result status
  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_EMPTY    = 2'd1,
    STS_NOTFOUND = 2'd2,
    STS_FULL     = 2'd3
  } status_t;

  // where a cell takes its next contents from
  typedef enum logic [2:0] {
    SEL_HOLD = 3'd0,
    SEL_NEW  = 3'd1,
    SEL_PREV = 3'd2,
    SEL_NEXT = 3'd3,
    SEL_HEAD = 3'd4
  } sel_t;

endpackage

@@ rtl/bounded_list_with_value_delete_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_with_value_delete_unit
// Ordered list of signed 32-bit values held in a row of cells, front in
// cell 0. Insert front shifts right; delete front and by value shift left.
// ----------------------------------------------------------------------------
// Inserts, delete front and delete back: one item per cycle while the output
//   is free; the result goes straight into the output register on acceptance.
// Delete value: the scan position walks one cell per cycle, each cell
//   comparing its entry with the key; one item is in flight at a time.
// Display: one result per entry, one per cycle while the output is free, read
//   from cell 0 while the row rotates; the list is back in order at the end.
// Reset: clears the entry count and control state; cell contents are left
//   as they are and need no clearing pass.
module bounded_list_with_value_delete_unit
  import blv_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [2:0]  s_tuser,   // [2:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] out_value
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_SHOW = 3'b100
  } state_t;

  state_t                st, st_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         idx, idx_next;
  value_t                key, key_next;
  logic [CAPACITY-1:0]   scan_mask, scan_next;

  value_t                cell_q [CAPACITY];
  logic [CAPACITY-1:0]   cell_eq;
  sel_t                  sel [CAPACITY];

  logic [CAPACITY-1:0]   occ, tail_free, last_occ, cur;

  logic                  out_free, in_fire, full, empty;
  logic                  hit, show_last;
  value_t                back_val;

  logic                  do_ins_back, do_ins_front, do_del_front;
  logic                  do_hit_shift, do_rotate;
  logic                  load;
  status_t               ld_status;
  value_t                ld_value;
  logic                  ld_last;

  // handshake
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (st == ST_IDLE) && out_free;
  assign in_fire  = s_tvalid && s_tready;
  assign full     = (count == CW'(CAPACITY));
  assign empty    = (count == '0);
  assign show_last = (({1'b0, idx} + 1'b1) == {1'b0, count});

  // per-cell position flags and the row of cells
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    value_t prev_v, next_v;

    assign occ[j] = (count > CW'(j));

    if (j == 0) begin : g_first
      assign tail_free[j] = !occ[j];
      assign cur[j]       = !scan_mask[j];
      assign prev_v       = cell_q[j];
    end else begin : g_rest
      assign tail_free[j] = !occ[j] && occ[j-1];
      assign cur[j]       = !scan_mask[j] && scan_mask[j-1];
      assign prev_v       = cell_q[j-1];
    end

    if (j == CAPACITY - 1) begin : g_end
      assign last_occ[j] = occ[j];
      assign next_v      = cell_q[j];
    end else begin : g_mid
      assign last_occ[j] = occ[j] && !occ[j+1];
      assign next_v      = cell_q[j+1];
    end

    // data select for this cell
    always_comb begin
      sel[j] = SEL_HOLD;
      if (do_ins_back && tail_free[j]) begin
        sel[j] = SEL_NEW;
      end else if (do_ins_front) begin
        sel[j] = (j == 0) ? SEL_NEW : SEL_PREV;
      end else if (do_del_front) begin
        sel[j] = (j < CAPACITY - 1) ? SEL_NEXT : SEL_HOLD;
      end else if (do_hit_shift && !scan_mask[j]) begin
        sel[j] = (j < CAPACITY - 1) ? SEL_NEXT : SEL_HOLD;
      end else if (do_rotate && occ[j]) begin
        sel[j] = last_occ[j] ? SEL_HEAD : SEL_NEXT;
      end
    end

    blv_cell u_cell (
      .clk        (clk),
      .sel        (sel[j]),
      .new_value  (value_t'(s_tdata)),
      .prev_value (prev_v),
      .next_value (next_v),
      .head_value (cell_q[0]),
      .key        (key),
      .q          (cell_q[j]),
      .eq         (cell_eq[j])
    );
  end

  // back entry and match at the scan position
  always_comb begin
    back_val = '0;
    hit      = 1'b0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (last_occ[j]) back_val = back_val | cell_q[j];
      hit = hit | (cur[j] && occ[j] && cell_eq[j]);
    end
  end

  // scan position moves one cell on
  always_comb begin
    scan_next[0] = 1'b1;
    for (int j = 1; j < CAPACITY; j++) scan_next[j] = scan_mask[j-1];
  end

  // control
  always_comb begin
    st_next      = st;
    count_next   = count;
    idx_next     = idx;
    key_next     = key;
    do_ins_back  = 1'b0;
    do_ins_front = 1'b0;
    do_del_front = 1'b0;
    do_hit_shift = 1'b0;
    do_rotate    = 1'b0;
    load         = 1'b0;
    ld_status    = STS_OK;
    ld_value     = '0;
    ld_last      = 1'b1;
    unique case (st)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (s_tuser)
            REQ_INS_BACK: begin
              load = 1'b1;
              if (full) begin
                ld_status = STS_FULL;
              end else begin
                do_ins_back = 1'b1;
                count_next  = count + 1'b1;
              end
            end
            REQ_INS_FRONT: begin
              load = 1'b1;
              if (full) begin
                ld_status = STS_FULL;
              end else begin
                do_ins_front = 1'b1;
                count_next   = count + 1'b1;
              end
            end
            REQ_DEL_VALUE: begin
              if (empty) begin
                load      = 1'b1;
                ld_status = STS_EMPTY;
              end else begin
                key_next = value_t'(s_tdata);
                idx_next = '0;
                st_next  = ST_SCAN;
              end
            end
            REQ_DEL_FRONT: begin
              load = 1'b1;
              if (empty) begin
                ld_status = STS_EMPTY;
              end else begin
                ld_value     = cell_q[0];
                do_del_front = 1'b1;
                count_next   = count - 1'b1;
              end
            end
            REQ_DEL_BACK: begin
              load = 1'b1;
              if (empty) begin
                ld_status = STS_EMPTY;
              end else begin
                ld_value   = back_val;
                count_next = count - 1'b1;
              end
            end
            REQ_DISPLAY: begin
              if (empty) begin
                load      = 1'b1;
                ld_status = STS_EMPTY;
              end else begin
                idx_next = '0;
                st_next  = ST_SHOW;
              end
            end
            default: ;  // unused codes: no result
          endcase
        end
      end
      ST_SCAN: begin
        if (idx == count) begin
          load      = 1'b1;
          ld_status = STS_NOTFOUND;
          st_next   = ST_IDLE;
        end else if (hit) begin
          load         = 1'b1;
          ld_value     = key;
          do_hit_shift = 1'b1;
          count_next   = count - 1'b1;
          st_next      = ST_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_SHOW: begin
        if (out_free) begin
          load      = 1'b1;
          ld_value  = cell_q[0];
          ld_last   = show_last;
          do_rotate = 1'b1;
          idx_next  = idx + 1'b1;
          if (show_last) st_next = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= ST_IDLE;
      count <= '0;
    end else begin
      st    <= st_next;
      count <= count_next;
    end
  end

  // scan bookkeeping, no reset needed
  always_ff @(posedge clk) begin
    idx <= idx_next;
    key <= key_next;
    if (st == ST_IDLE) begin
      scan_mask <= '0;
    end else if (st == ST_SCAN) begin
      scan_mask <= scan_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tuser <= ld_status;
      m_tdata <= ld_value;
      m_tlast <= ld_last;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (st == ST_IDLE))
    else $error("item taken while busy");

  a_scan_quiet: assert property (@(posedge clk) disable iff (rst)
    (st == ST_SCAN) |-> !m_tvalid)
    else $error("result pending during search");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (in_fire && full && (s_tuser == REQ_INS_BACK || s_tuser == REQ_INS_FRONT))
    |=> $stable(count))
    else $error("insert on full list changed count");

endmodule

@@ rtl/blv_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blv_cell
// One list slot: holds an entry, loads it from the new value, a neighbouring
// cell or the head cell, and compares it against the search key.
// ----------------------------------------------------------------------------
module blv_cell
  import blv_pkg::*;
(
  input  logic   clk,
  input  sel_t   sel,
  input  value_t new_value,
  input  value_t prev_value,
  input  value_t next_value,
  input  value_t head_value,
  input  value_t key,
  output value_t q,
  output logic   eq
);

  // slot register
  always_ff @(posedge clk) begin
    case (sel)
      SEL_NEW:  q <= new_value;
      SEL_PREV: q <= prev_value;
      SEL_NEXT: q <= next_value;
      SEL_HEAD: q <= head_value;
      default:  q <= q;
    endcase
  end

  // local match against the search key
  assign eq = (q == key);

endmodule
